FILE: design/rtu_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte update for the RTU frame checker.
`timescale 1ns / 1ps
`default_nettype none

package rtu_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned CRC_W    = 16;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned COUNT_W  = 3;

   localparam logic [CRC_W-1:0]   CRC_INIT      = 16'hFFFF;
   localparam logic [CRC_W-1:0]   CRC_POLY      = 16'hA001;
   localparam logic [BYTE_W-1:0]  STATION_RESET = 8'h01;

   // Byte count saturates here; a frame is long enough once it reaches it.
   localparam logic [COUNT_W-1:0] COUNT_SAT     = 3'd4;
   localparam logic [COUNT_W-1:0] POS_ADDRESS   = 3'd0;
   localparam logic [COUNT_W-1:0] POS_FUNCTION  = 3'd1;
   localparam logic [COUNT_W-1:0] POS_PAYLOAD   = 3'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_ACCEPT        = 2'd0,
      ST_ADDR_MISMATCH = 2'd1,
      ST_CRC_MISMATCH  = 2'd2,
      ST_TOO_SHORT     = 2'd3
   } status_type;

   // Reflected CRC-16 update over one byte, LSB first.
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
      for (int i = 0; i < BYTE_W; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: design/rtu_stream_if.sv
// Valid/ready channel interfaces for received frame bytes and check results.
`timescale 1ns / 1ps
`default_nettype none

interface rtu_req_if
   import rtu_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;
   logic              frame_end;

   modport source (output valid, output rx_byte, output frame_end, input ready);
   modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface rtu_rsp_if
   import rtu_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] check_status;
   logic [BYTE_W-1:0]   func_code;
   logic [CRC_W-1:0]    computed_crc;

   modport source (output valid, output check_status, output func_code,
                   output computed_crc, input ready);
   modport sink   (input valid, input check_status, input func_code,
                   input computed_crc, output ready);
endinterface

`default_nettype wire

FILE: design/rtu_frame_address_crc_check_top.sv
// Modbus RTU receive frame checker: station address, length and CRC-16/MODBUS.
//
// Frame bytes arrive on req_chan, one per transfer, with frame_end set on the
// last byte. The first byte is compared with the station address held in the
// csr register, the second is kept as the function code, and a CRC-16/MODBUS
// runs over every byte except the trailing two, which are held back and
// compared with the CRC (low byte first) when the frame ends.
// Only the transfer that carries frame_end produces a result on rsp_chan; it
// appears in the cycle after that transfer. The block takes one byte per cycle,
// back to back unless a stalled result holds it off; the CRC byte update is unrolled.
// One result register sits between the channels: a new byte is taken
// whenever the result register is empty or is being drained in the
// same cycle. When rsp_chan stalls with a result waiting, req_chan.ready
// drops until the result is taken; the held result keeps its value.
// Reset clears the frame state, empties the result register and sets the
// station address to 1. A csr write takes effect from the next frame start.
`timescale 1ns / 1ps
`default_nettype none

module rtu_frame_address_crc_check_top
   import rtu_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write_enable,
   input  wire logic [BYTE_W-1:0] csr_write_data,
   rtu_req_if.sink                req_chan,
   rtu_rsp_if.source              rsp_chan
);

   logic [BYTE_W-1:0]   station_ff;
   logic [CRC_W-1:0]    crc_ff,    crc_in;
   logic [COUNT_W-1:0]  count_ff,  count_in;
   logic [BYTE_W-1:0]   held0_ff,  held0_in;
   logic [BYTE_W-1:0]   held1_ff,  held1_in;
   logic                match_ff,  match_in;
   logic [BYTE_W-1:0]   func_ff,   func_in;

   logic                out_valid_ff;
   status_type          status_ff, status_in;
   logic [BYTE_W-1:0]   out_func_ff, out_func_in;
   logic [CRC_W-1:0]    out_crc_ff;

   logic                req_fire;
   logic                rsp_fire;
   logic [CRC_W-1:0]    received;

   assign rsp_fire       = out_valid_ff & rsp_chan.ready;
   assign req_chan.ready = ~out_valid_ff | rsp_chan.ready;
   assign req_fire       = req_chan.valid & req_chan.ready;

   always_comb begin
      match_in = (count_ff == POS_ADDRESS)
                 ? (req_chan.rx_byte == station_ff) : match_ff;
      func_in  = (count_ff == POS_FUNCTION) ? req_chan.rx_byte : func_ff;
      // The older held byte leaves the delay line and enters the CRC.
      crc_in   = (count_ff >= POS_PAYLOAD) ? crc_byte(crc_ff, held0_ff) : crc_ff;
      held0_in = held1_ff;
      held1_in = req_chan.rx_byte;
      count_in = (count_ff < COUNT_SAT) ? count_ff + 3'd1 : count_ff;
      received = {held1_in, held0_in};

      if (count_in < COUNT_SAT) begin
         status_in = ST_TOO_SHORT;
      end else if (!match_in) begin
         status_in = ST_ADDR_MISMATCH;
      end else if (received != crc_in) begin
         status_in = ST_CRC_MISMATCH;
      end else begin
         status_in = ST_ACCEPT;
      end
      out_func_in = (count_in >= POS_PAYLOAD) ? func_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         station_ff <= STATION_RESET;
      end else if (csr_write_enable) begin
         station_ff <= csr_write_data;
      end
   end

   // Frame state: advance on every byte, return to the idle values after the last.
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= CRC_INIT;
         count_ff <= '0;
         held0_ff <= '0;
         held1_ff <= '0;
         match_ff <= 1'b0;
         func_ff  <= '0;
      end else if (req_fire) begin
         if (req_chan.frame_end) begin
            crc_ff   <= CRC_INIT;
            count_ff <= '0;
            held0_ff <= '0;
            held1_ff <= '0;
            match_ff <= 1'b0;
            func_ff  <= '0;
         end else begin
            crc_ff   <= crc_in;
            count_ff <= count_in;
            held0_ff <= held0_in;
            held1_ff <= held1_in;
            match_ff <= match_in;
            func_ff  <= func_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (req_fire && req_chan.frame_end) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_fire) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_chan.frame_end) begin
         status_ff   <= status_in;
         out_func_ff <= out_func_in;
         out_crc_ff  <= crc_in;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.check_status = status_ff;
   assign rsp_chan.func_code    = out_func_ff;
   assign rsp_chan.computed_crc = out_crc_ff;

endmodule

`default_nettype wire

FILE: design/rtu_check.sv
// Port-level assertions for the RTU frame checker and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rtu_check
   import rtu_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                req_frame_end,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [STATUS_W-1:0] rsp_check_status,
   input wire logic [BYTE_W-1:0]   rsp_func_code,
   input wire logic [CRC_W-1:0]    rsp_computed_crc
);

   logic last_fire;
   assign last_fire = req_valid & req_ready & req_frame_end;

   // A stalled result holds its value until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_check_status)
         && $stable(rsp_func_code) && $stable(rsp_computed_crc))
      else $error("result changed or dropped while stalled");

   // Every accepted final byte yields a result in the next cycle.
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      last_fire |=> rsp_valid)
      else $error("no result after the final byte of a frame");

   // A result only appears after a final byte was accepted.
   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(last_fire))
      else $error("result without a finished frame");

   // A drained result is not repeated unless another frame ended.
   a_no_repeat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !last_fire |=> !rsp_valid)
      else $error("result repeated after its transfer");

endmodule

bind rtu_frame_address_crc_check_top rtu_check u_rtu_check (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .req_frame_end     (req_chan.frame_end),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_check_status  (rsp_chan.check_status),
   .rsp_func_code     (rsp_chan.func_code),
   .rsp_computed_crc  (rsp_chan.computed_crc)
);

`default_nettype wire

FILE: verif/rtu_frame_address_crc_check_top_tb.sv
// Self-checking testbench for the RTU frame checker: stimulus, predictor, result compare.
`timescale 1ns / 1ps

module rtu_frame_address_crc_check_top_tb
   import rtu_pkg::*;
;

   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } rx_item_type;

   typedef struct packed {
      status_type          status;
      logic [BYTE_W-1:0]   func_code;
      logic [CRC_W-1:0]    computed_crc;
   } frame_check_type;

   typedef enum int {
      FAULT_NONE,
      FAULT_FLIP,
      FAULT_SWAP
   } crc_fault_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              drv_valid = 1'b0;
   logic [BYTE_W-1:0] drv_byte  = '0;
   logic              drv_last  = 1'b0;
   logic              rsp_ready = 1'b0;
   logic              csr_we    = 1'b0;
   logic [BYTE_W-1:0] csr_wd    = '0;

   rtu_req_if req_bus ();
   rtu_rsp_if rsp_bus ();

   assign req_bus.valid     = drv_valid;
   assign req_bus.rx_byte   = drv_byte;
   assign req_bus.frame_end = drv_last;
   assign rsp_bus.ready     = rsp_ready;

   rtu_frame_address_crc_check_top u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_we),
      .csr_write_data   (csr_wd),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Stimulus and scoreboard state.
   rx_item_type     byte_q[$];
   frame_check_type pending_checks[$];
   int              sender_idle_pct = 0;
   int              recv_stall_pct  = 0;
   int              items_queued    = 0;
   int              bytes_sent      = 0;
   int              csr_writes      = 0;
   int              error_count     = 0;
   int              status_tally[4] = '{0, 0, 0, 0};
   int              cycle_count     = 0;

   // Predictor copy of the frame state and the station register.
   logic [BYTE_W-1:0]  station_addr = STATION_RESET;
   logic [CRC_W-1:0]   frm_crc      = CRC_INIT;
   logic [COUNT_W-1:0] frm_count    = '0;
   logic [BYTE_W-1:0]  frm_held[2]  = '{8'h00, 8'h00};
   logic               frm_addr_ok  = 1'b0;
   logic [BYTE_W-1:0]  frm_func     = '0;

   // Bit-serial form of the reflected CRC-16 update, LSB of the byte first.
   function automatic logic [CRC_W-1:0] crc16_update(input logic [CRC_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc;
      for (int i = 0; i < BYTE_W; i++) begin
         if (c[0] ^ b[i]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   task automatic predict_frame_byte(input logic [BYTE_W-1:0] b, input logic last);
      frame_check_type   r;
      logic [CRC_W-1:0]  trailer;
      if (frm_count == POS_ADDRESS) frm_addr_ok = (b == station_addr);
      if (frm_count == POS_FUNCTION) frm_func = b;
      // The older held byte leaves the delay line and enters the CRC.
      if (frm_count >= POS_PAYLOAD) frm_crc = crc16_update(frm_crc, frm_held[0]);
      frm_held[0] = frm_held[1];
      frm_held[1] = b;
      if (frm_count < COUNT_SAT) frm_count = frm_count + 1'b1;
      if (last) begin
         trailer = {frm_held[1], frm_held[0]};
         if (frm_count < COUNT_SAT) begin
            r.status = ST_TOO_SHORT;
         end else if (!frm_addr_ok) begin
            r.status = ST_ADDR_MISMATCH;
         end else if (trailer != frm_crc) begin
            r.status = ST_CRC_MISMATCH;
         end else begin
            r.status = ST_ACCEPT;
         end
         // A function code exists once at least two bytes have arrived.
         r.func_code    = (frm_count >= POS_PAYLOAD) ? frm_func : '0;
         r.computed_crc = frm_crc;
         pending_checks.push_back(r);
         frm_crc     = CRC_INIT;
         frm_count   = '0;
         frm_held[0] = '0;
         frm_held[1] = '0;
         frm_addr_ok = 1'b0;
         frm_func    = '0;
      end
   endtask

   // Driver: presents queued bytes, holds each until its transfer.
   always @(posedge clock) begin
      if (reset) begin
         drv_valid <= 1'b0;
      end else begin
         if (drv_valid && req_bus.ready) begin
            predict_frame_byte(drv_byte, drv_last);
            bytes_sent++;
         end
         if (!drv_valid || req_bus.ready) begin
            if (byte_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               drv_valid <= 1'b1;
               drv_byte  <= byte_q[0].data;
               drv_last  <= byte_q[0].last;
               void'(byte_q.pop_front());
            end else begin
               drv_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares each result transfer with the oldest pending check.
   frame_check_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_ready) begin
            if (pending_checks.size() == 0) begin
               $error("unexpected result: check_status %0d func_code %0h computed_crc %0h",
                      rsp_bus.check_status, rsp_bus.func_code, rsp_bus.computed_crc);
               error_count++;
            end else begin
               want = pending_checks.pop_front();
               status_tally[want.status]++;
               if (rsp_bus.check_status !== want.status) begin
                  $error("check_status expected %0d actual %0d", want.status,
                         rsp_bus.check_status);
                  error_count++;
               end
               if (rsp_bus.func_code !== want.func_code) begin
                  $error("func_code expected %0h actual %0h", want.func_code,
                         rsp_bus.func_code);
                  error_count++;
               end
               if (rsp_bus.computed_crc !== want.computed_crc) begin
                  $error("computed_crc expected %0h actual %0h", want.computed_crc,
                         rsp_bus.computed_crc);
                  error_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last);
      byte_q.push_back('{data: b, last: last});
      items_queued++;
   endtask

   // Queues a frame of 4 + extra_len bytes, closed by its CRC low byte first.
   task automatic queue_frame(input logic [BYTE_W-1:0] addr, input logic [BYTE_W-1:0] func,
                              input int extra_len, input crc_fault_type fault);
      logic [BYTE_W-1:0] body[$];
      logic [CRC_W-1:0]  crc;
      body.push_back(addr);
      body.push_back(func);
      repeat (extra_len) body.push_back(8'($urandom_range(0, 255)));
      crc = CRC_INIT;
      foreach (body[i]) crc = crc16_update(crc, body[i]);
      case (fault)
         FAULT_FLIP: crc = crc ^ (16'h0001 << $urandom_range(0, 15));
         FAULT_SWAP: crc = {crc[7:0], crc[15:8]};
         default: ;
      endcase
      foreach (body[i]) push_byte(body[i], 1'b0);
      push_byte(crc[7:0], 1'b0);
      push_byte(crc[15:8], 1'b1);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (byte_q.size() != 0 || drv_valid || pending_checks.size() != 0);
      // The result register is loaded in the cycle after the last transfer.
      repeat (3) @(negedge clock);
   endtask

   task automatic write_station(input logic [BYTE_W-1:0] addr);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wd <= addr;
      @(posedge clock);
      csr_we <= 1'b0;
      station_addr = addr;
      csr_writes++;
      @(negedge clock);
   endtask

   task automatic queue_random_frames(input int n_items);
      int                target;
      int                kind;
      int                extra;
      logic [BYTE_W-1:0] addr;
      target = items_queued + n_items;
      while (items_queued < target) begin
         kind  = $urandom_range(0, 99);
         extra = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
         if (kind < 65) begin
            queue_frame(station_addr, 8'($urandom_range(0, 255)), extra, FAULT_NONE);
         end else if (kind < 75) begin
            if (kind[0]) begin
               addr = station_addr ^ (8'h01 << $urandom_range(0, 7));
            end else begin
               addr = 8'($urandom_range(0, 255));
            end
            queue_frame(addr, 8'($urandom_range(0, 255)), extra, FAULT_NONE);
         end else if (kind < 85) begin
            queue_frame(station_addr, 8'($urandom_range(0, 255)), extra,
                        kind[0] ? FAULT_FLIP : FAULT_SWAP);
         end else if (kind < 93) begin
            repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)), 1'b0);
            push_byte(8'($urandom_range(0, 255)), 1'b1);
         end else begin
            // Stray byte; without an end flag it runs into the next frame.
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
         end
      end
   endtask

   logic [BYTE_W-1:0] phase_addr[5];
   int                phase_sender[5] = '{0, 74, 0, 35, 0};
   int                phase_recv[5]   = '{0, 0, 74, 35, 0};
   logic [CRC_W-1:0]  split_crc;

   initial begin
      phase_addr[0] = 8'h00;
      phase_addr[1] = 8'hFF;
      phase_addr[2] = 8'($urandom_range(0, 255));
      phase_addr[3] = 8'($urandom_range(0, 255));
      phase_addr[4] = STATION_RESET;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed frames against the reset station address.
      push_byte(8'hFF, 1'b1);
      push_byte(8'h01, 1'b0);
      push_byte(8'h03, 1'b1);
      push_byte(8'h01, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b1);
      queue_frame(STATION_RESET, 8'h00, 0, FAULT_NONE);
      queue_frame(8'hFF, 8'h03, 0, FAULT_NONE);
      // Address mismatch must win over a bad CRC.
      queue_frame(8'h00, 8'hFF, 0, FAULT_FLIP);
      // High byte first on the trailer must be caught.
      queue_frame(STATION_RESET, 8'h10, 0, FAULT_SWAP);
      push_byte(STATION_RESET, 1'b0);
      push_byte(8'h06, 1'b0);
      wait_idle();
      // A write in the middle of a frame leaves its address check alone.
      write_station(8'h55);
      split_crc = crc16_update(crc16_update(CRC_INIT, STATION_RESET), 8'h06);
      push_byte(split_crc[7:0], 1'b0);
      push_byte(split_crc[15:8], 1'b1);
      queue_frame(8'h55, 8'h2B, 0, FAULT_NONE);
      wait_idle();

      for (int p = 0; p < 5; p++) begin
         write_station(phase_addr[p]);
         sender_idle_pct = phase_sender[p];
         recv_stall_pct  = phase_recv[p];
         queue_random_frames(155);
         // The sender holds off here until every pending result is in.
         wait_idle();
         queue_random_frames(155);
         wait_idle();
      end
      repeat (8) @(negedge clock);

      if (pending_checks.size() != 0) begin
         $error("%0d frame checks never arrived", pending_checks.size());
         error_count++;
      end
      $display("%0d bytes sent over %0d station settings (%0d csr writes)",
               bytes_sent, csr_writes + 1, csr_writes);
      $display("frame results: %0d accepted, %0d address mismatch, %0d crc mismatch, %0d short",
               status_tally[ST_ACCEPT], status_tally[ST_ADDR_MISMATCH],
               status_tally[ST_CRC_MISMATCH], status_tally[ST_TOO_SHORT]);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/rtu_pkg.sv
design/rtu_stream_if.sv
design/rtu_frame_address_crc_check_top.sv
design/rtu_check.sv
verif/rtu_frame_address_crc_check_top_tb.sv
